// ----- design/acc_pkg.sv -----
`timescale 1ns / 1ps

package acc_pkg;

	localparam int CHAN_N    = 8;
	localparam int CHAN_W    = 3;
	localparam int SMP_W     = 12;
	localparam int GAIN_W    = 15;
	localparam int BIAS_W    = 13;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 15;

	localparam logic [SMP_W-1:0] SMP_MAX    = 12'd4095;
	localparam logic [SMP_W-1:0] POT0_RESET = 12'd2354;
	localparam logic [SMP_W-1:0] TAKEOVER   = 12'd100;
	localparam logic [GAIN_W-1:0] GAIN_UNITY = 15'd4096;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_0 = 3'd4;

	typedef enum logic [1:0] {
		OP_WRITE     = 2'd0,
		OP_READ_PROC = 2'd1,
		OP_ARM       = 2'd2,
		OP_READ_RAW  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic capture;   // take the input beat into the item registers
		logic sel_pair;  // read the paired CV channel for a processed pot read
		logic mul;       // register the gain product
		logic exec;      // perform write/arm/raw read and load the result
		logic fin;       // load the processed result
	} cmd_t;

	typedef struct packed {
		logic proc;      // item held is a processed read
	} stat_t;

endpackage

// ----- design/acc_ctrl.sv -----
`timescale 1ns / 1ps

module acc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  acc_pkg::stat_t stat,
	output acc_pkg::cmd_t  cmd
);

	acc_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;
	logic load;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign load      = cmd.exec || cmd.fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= acc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			acc_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid)
					state_d = acc_pkg::ST_MUL;
			end
			acc_pkg::ST_MUL: begin
				cmd.sel_pair = 1'b1;
				if (stat.proc) begin
					cmd.mul = 1'b1;
					state_d = acc_pkg::ST_FIN;
				end else if (out_free) begin
					cmd.exec = 1'b1;
					state_d  = acc_pkg::ST_IDLE;
				end
			end
			acc_pkg::ST_FIN: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = acc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = acc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/acc_dp.sv -----
`timescale 1ns / 1ps

module acc_dp #(
	parameter int NUM_POTS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  acc_pkg::cmd_t                  cmd,
	output acc_pkg::stat_t                 stat,
	input  logic [1:0]                     in_op,
	input  logic [acc_pkg::CHAN_W-1:0]     in_ch,
	input  logic [acc_pkg::SMP_W-1:0]      in_smp,
	input  logic                           cfg_we,
	input  logic [acc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [acc_pkg::CFG_DAT_W-1:0]  cfg_dat,
	output logic [acc_pkg::SMP_W-1:0]      out_data,
	output logic                           out_stored
);

	localparam int SW = acc_pkg::SMP_W;

	// item registers
	acc_pkg::op_t              op_q;
	logic [acc_pkg::CHAN_W-1:0] ch_q;
	logic [SW-1:0]             smp_q;

	// state and configuration
	logic [SW-1:0]                   vals_q [acc_pkg::CHAN_N];
	logic [NUM_POTS-1:0]             frozen_q;
	logic [acc_pkg::GAIN_W-1:0]      gain_q [4];
	logic signed [acc_pkg::BIAS_W-1:0] bias_q [4];

	// product stage
	logic signed [27:0]               prod_s1;
	logic signed [acc_pkg::BIAS_W-1:0] bias_s1;

	logic [SW-1:0]  data_q;
	logic           stored_q;

	logic                       is_pot;
	logic [NUM_POTS-1:0]        pot_dec;
	logic                       frozen_hit;
	logic [acc_pkg::CHAN_W-1:0] rd_addr;
	logic [SW-1:0]              rd;
	logic signed [12:0]         s_ctr;
	logic signed [28:0]         prod_full;
	logic signed [12:0]         diff;
	logic                       far;
	logic                       do_store;
	logic                       do_arm;

	logic signed [15:0] q_floor;
	logic signed [16:0] p_sum;
	logic [SW-1:0]      p_cl;
	logic signed [12:0] e_ctr;
	logic signed [24:0] m_scaled;
	logic signed [24:0] m_adj;
	logic signed [13:0] d_pot;
	logic signed [14:0] t_sum;
	logic [SW-1:0]      t_cl;
	logic [SW-1:0]      fin_data;

	assign is_pot = {1'b0, ch_q} < 4'(NUM_POTS);

	for (genvar i = 0; i < NUM_POTS; i++) begin : g_dec
		assign pot_dec[i] = (ch_q == acc_pkg::CHAN_W'(i));
	end
	assign frozen_hit = |(frozen_q & pot_dec);

	assign stat.proc = (op_q == acc_pkg::OP_READ_PROC);

	assign rd_addr = (cmd.sel_pair && stat.proc && is_pot) ? ch_q + 3'd4 : ch_q;
	assign rd      = vals_q[rd_addr];

	// centre on 2048 and apply the Q3.12 gain
	assign s_ctr     = $signed({1'b0, rd}) - 13'sd2048;
	assign prod_full = 29'(s_ctr) * $signed({14'd0, gain_q[rd_addr[1:0]]});

	// soft takeover
	assign diff     = $signed({1'b0, smp_q}) - $signed({1'b0, rd});
	assign far      = (diff > $signed({1'b0, acc_pkg::TAKEOVER}))
		|| (diff < -$signed({1'b0, acc_pkg::TAKEOVER}));
	assign do_store = cmd.exec && (op_q == acc_pkg::OP_WRITE)
		&& !(is_pot && frozen_hit && !far);
	assign do_arm   = cmd.exec && (op_q == acc_pkg::OP_ARM) && is_pot;

	// floor of product / 4096, bias, re-centre, clamp
	assign q_floor = prod_s1[27:12];
	assign p_sum   = 17'(q_floor) + 17'(bias_s1) + 17'sd2048;
	assign p_cl    = (p_sum < 0) ? '0
		: (p_sum > $signed({5'd0, acc_pkg::SMP_MAX})) ? acc_pkg::SMP_MAX : p_sum[SW-1:0];

	// (p - 2048) * 4095 / 2048, truncated toward zero
	assign e_ctr    = $signed({1'b0, p_cl}) - 13'sd2048;
	assign m_scaled = (25'(e_ctr) <<< 12) - 25'(e_ctr);
	assign m_adj    = (m_scaled < 0) ? m_scaled + 25'sd2047 : m_scaled;
	assign d_pot    = m_adj[24:11];
	assign t_sum    = $signed({3'd0, rd}) + 15'(d_pot);
	assign t_cl     = (t_sum < 0) ? '0
		: (t_sum > $signed({3'd0, acc_pkg::SMP_MAX})) ? acc_pkg::SMP_MAX : t_sum[SW-1:0];

	assign fin_data = is_pot ? t_cl : p_cl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < acc_pkg::CHAN_N; i++)
				vals_q[i] <= (i == 0) ? acc_pkg::POT0_RESET : '0;
			frozen_q <= '0;
			for (int k = 0; k < 4; k++) begin
				gain_q[k] <= acc_pkg::GAIN_UNITY;
				bias_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_idx < acc_pkg::CFG_BIAS_0)
					gain_q[cfg_idx[1:0]] <= cfg_dat;
				else
					bias_q[cfg_idx[1:0]] <= $signed(cfg_dat[acc_pkg::BIAS_W-1:0]);
			end
			if (do_store)
				vals_q[ch_q] <= smp_q;
			for (int i = 0; i < NUM_POTS; i++) begin
				if (pot_dec[i] && do_arm)
					frozen_q[i] <= 1'b1;
				else if (pot_dec[i] && do_store)
					frozen_q[i] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= acc_pkg::op_t'(in_op);
			ch_q  <= in_ch;
			smp_q <= in_smp;
		end
		if (cmd.mul) begin
			prod_s1 <= prod_full[27:0];
			bias_s1 <= bias_q[rd_addr[1:0]];
		end
		if (cmd.exec) begin
			data_q   <= do_store ? smp_q : rd;
			stored_q <= do_store;
		end else if (cmd.fin) begin
			data_q   <= fin_data;
			stored_q <= 1'b0;
		end
	end

	assign out_data   = data_q;
	assign out_stored = stored_q;

endmodule

// ----- design/adc_channel_conditioner.sv -----
`timescale 1ns / 1ps
// ADC channel conditioner: holds eight 12-bit channel values. Channels below
// NUM_POTS are pots with soft takeover, the rest are control voltages.
// Input stream: one beat per operation. tuser carries opcode and channel,
// tdata the sample (used by writes only). Output stream: one beat per
// operation. tdata carries the channel value, tuser the stored flag.
// Configuration channel: cfg_index 0..3 selects a CV gain (Q3.12), 4..7 a
// CV bias in counts; always ready, write only while no operation is active.
// Timing: a beat is taken in the idle state. Writes, arms and raw reads
// load their result from the multiply state; processed reads register the
// gain product in the multiply state, then apply bias, clamp and the pot
// rescale and load the result in the finish state. The next beat is taken
// only after the result is loaded and the block is back in idle.
// The result sits in an output register; a stalled receiver holds it, and
// the block holds its next result (and stops taking input) until taken.
// Reset clears all channels to 0 except pot 0 (2354), clears all freezes,
// sets every gain to unity and every bias to zero.
module adc_channel_conditioner #(
	parameter int NUM_POTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [11:0] sample
	input  logic [4:0]  s_axis_tuser,   // [1:0] opcode, [4:2] channel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [11:0] data
	output logic        m_axis_tuser,   // [0] stored
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	acc_pkg::cmd_t  cmd;
	acc_pkg::stat_t stat;
	logic [acc_pkg::SMP_W-1:0] out_data;

	// configuration writes never stall
	assign cfg_ready = 1'b1;

	acc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	acc_dp #(
		.NUM_POTS (NUM_POTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_op      (s_axis_tuser[1:0]),
		.in_ch      (s_axis_tuser[4:2]),
		.in_smp     (s_axis_tdata[11:0]),
		.cfg_we     (cfg_valid),
		.cfg_idx    (cfg_index),
		.cfg_dat    (cfg_data),
		.out_data   (out_data),
		.out_stored (m_axis_tuser)
	);

	// pad the result to whole bytes
	assign m_axis_tdata = {4'd0, out_data};

endmodule
